/* rtl/core/chr_pkg.sv */
// Shared types and constants for the consistent hash ring.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package chr_pkg;

    localparam int ID_W       = 17;
    localparam int LABEL_W    = 19;
    localparam int HASH_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int BYTE_W     = 8;
    localparam int REPLICAS   = 3;
    localparam int CMD_DEPTH  = 2;

    localparam logic [LABEL_W-1:0] LABEL_STEP = 19'd100000;
    localparam logic [HASH_W-1:0]  KEY_SEED   = 32'd5381;
    localparam logic [HASH_W-1:0]  MIX_MUL    = 32'h045d9f3b;

    // Input kinds carried on the slave tuser.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_LOOKUP,
        CMD_BADID
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [ID_W-1:0]     id;
        logic [HASH_W-1:0]   hash;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HASH_W-1:0]   hash;
    } ring_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_SCAN,
        S_MIX1,
        S_MIX2,
        S_FIND,
        S_SHIFT,
        S_PLACE,
        S_REMOVE,
        S_LOOKUP,
        S_WRAP,
        S_WRAP_RD,
        S_REPLY
    } back_state_t;

endpackage

/* rtl/core/chr_front.sv */
// Front end: accepts input transactions, runs the djb2 key hash and
// queues ring commands. Depends on chr_pkg.
`timescale 1ns / 1ps

module chr_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                in_kind,
    input  logic [chr_pkg::ID_W-1:0]  in_id,
    input  logic [chr_pkg::BYTE_W-1:0] in_byte,
    input  logic                      in_last,
    output logic                      push_valid,
    input  logic                      push_ready,
    output chr_pkg::cmd_t             push_data
);
    import chr_pkg::*;

    logic [HASH_W-1:0] key_hash_reg;
    logic [HASH_W-1:0] key_hash_next;
    logic [HASH_W-1:0] hash_step;
    logic              accept;
    logic              needs_push;

    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign hash_step = (key_hash_reg << 5) + key_hash_reg + {{(HASH_W-BYTE_W){1'b0}}, in_byte};

    always_comb
    begin
        needs_push    = 1'b0;
        key_hash_next = key_hash_reg;
        push_data.op  = CMD_LOOKUP;
        push_data.id  = in_id;
        push_data.hash = hash_step;
        case (in_kind)
            KIND_ADD, KIND_REMOVE:
            begin
                needs_push = 1'b1;
                if ({2'b00, in_id} >= LABEL_STEP)
                    push_data.op = CMD_BADID;
                else if (in_kind == KIND_ADD)
                    push_data.op = CMD_ADD;
                else
                    push_data.op = CMD_REMOVE;
            end
            KIND_KEY:
            begin
                if (accept)
                    key_hash_next = in_last ? KEY_SEED : hash_step;
                needs_push = in_last;
            end
            default:
            begin
                needs_push = 1'b0;
            end
        endcase
    end

    assign push_valid = accept && needs_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_hash_reg <= KEY_SEED;
        else
            key_hash_reg <= key_hash_next;
    end

endmodule

/* rtl/core/chr_cmd_fifo.sv */
// Two-entry command queue between the front end and the ring engine.
// Depends on chr_pkg for the command type.
`timescale 1ns / 1ps

module chr_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  chr_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output chr_pkg::cmd_t pop_data
);
    import chr_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t            slot_reg [CMD_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != CW'(CMD_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/chr_back.sv */
// Ring engine: holds the sorted ring memory and carries out add, remove
// and lookup commands, one entry per cycle. Depends on chr_pkg.
`timescale 1ns / 1ps

module chr_back
#(
    parameter int MAX_SERVERS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  chr_pkg::cmd_t                  cmd_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [chr_pkg::ID_W-1:0]       out_id,
    output logic [chr_pkg::STATUS_W-1:0]   out_status
);
    import chr_pkg::*;

    localparam int DEPTH = MAX_SERVERS * REPLICAS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_SERVERS + 1);

    ring_entry_t ring_mem [DEPTH];
    ring_entry_t rd_reg;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic                 issue_on_reg, issue_on_next;
    logic                 pv_reg, pv_next;
    logic [AW-1:0]        paddr_reg, paddr_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [1:0]           rep_reg, rep_next;
    logic [LABEL_W-1:0]   label_reg, label_next;
    logic [HASH_W-1:0]    mix_reg, mix_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        wr_reg, wr_next;
    logic                 found_reg, found_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    ring_entry_t          wdata;

    logic                 issuing;
    logic                 scan_end;
    logic                 id_match;
    logic                 hash_gt;
    logic                 key_lt;
    logic                 slot_free;
    logic [HASH_W-1:0]    x0;
    logic [HASH_W-1:0]    x1;
    logic [HASH_W-1:0]    label_h;
    logic [AW-1:0]        find_pos;

    // Label hash: two multiply-xorshift rounds, one multiply per cycle.
    assign x0      = {{(HASH_W-LABEL_W){1'b0}}, label_reg}
                     ^ ({{(HASH_W-LABEL_W){1'b0}}, label_reg} >> 16);
    assign x1      = mix_reg ^ (mix_reg >> 16);
    assign label_h = mix_reg ^ (mix_reg >> 16);

    assign issuing   = (idx_reg < fill_reg);
    assign scan_end  = !pv_reg && !issuing;
    assign id_match  = pv_reg && (rd_reg.id == cmd_reg.id);
    assign hash_gt   = pv_reg && (rd_reg.hash > label_h);
    assign key_lt    = pv_reg && (cmd_reg.hash < rd_reg.hash);
    assign find_pos  = hash_gt ? paddr_reg : fill_reg[AW-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_data.op)
                        CMD_ADD:    state_next = S_DUP_SCAN;
                        CMD_REMOVE: state_next = S_REMOVE;
                        CMD_LOOKUP: state_next = (count_reg == '0) ? S_REPLY : S_LOOKUP;
                        default:    state_next = S_REPLY;
                    endcase
                end
            end
            S_DUP_SCAN:
            begin
                if (id_match)
                    state_next = S_REPLY;
                else if (scan_end)
                    state_next = (count_reg >= CW'(MAX_SERVERS)) ? S_REPLY : S_MIX1;
            end
            S_MIX1:    state_next = S_MIX2;
            S_MIX2:    state_next = S_FIND;
            S_FIND:
            begin
                if (hash_gt || scan_end)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!pv_reg && !issue_on_reg)
                    state_next = S_PLACE;
            end
            S_PLACE:   state_next = (rep_reg == 2'(REPLICAS - 1)) ? S_REPLY : S_MIX1;
            S_REMOVE:
            begin
                if (scan_end)
                    state_next = S_REPLY;
            end
            S_LOOKUP:
            begin
                if (key_lt)
                    state_next = S_REPLY;
                else if (scan_end)
                    state_next = S_WRAP;
            end
            S_WRAP:    state_next = S_WRAP_RD;
            S_WRAP_RD: state_next = S_REPLY;
            S_REPLY:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath control and memory access.
    always_comb
    begin
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        issue_on_next   = issue_on_reg;
        pv_next         = 1'b0;
        paddr_next      = paddr_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        rep_next        = rep_reg;
        label_next      = label_reg;
        mix_next        = mix_reg;
        pos_next        = pos_reg;
        wr_next         = wr_reg;
        found_next      = found_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        cmd_ready       = 1'b0;
        we              = 1'b0;
        waddr           = wr_reg;
        wdata           = rd_reg;
        raddr           = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready  = 1'b1;
                cmd_next   = cmd_data;
                idx_next   = '0;
                wr_next    = '0;
                found_next = 1'b0;
                res_id_next = cmd_data.id;
                res_status_next = ST_OK;
                if (cmd_data.op == CMD_BADID)
                begin
                    res_id_next     = '0;
                    res_status_next = ST_UNKNOWN;
                end
                else if (cmd_data.op == CMD_LOOKUP && count_reg == '0)
                begin
                    res_id_next     = '0;
                    res_status_next = ST_EMPTY;
                end
            end
            S_DUP_SCAN:
            begin
                pv_next    = issuing;
                paddr_next = idx_reg[AW-1:0];
                idx_next   = idx_reg + FW'(issuing);
                rep_next   = '0;
                label_next = {2'b00, cmd_reg.id};
                if (id_match)
                    res_status_next = ST_DUP;
                else if (count_reg >= CW'(MAX_SERVERS))
                    res_status_next = ST_FULL;
            end
            S_MIX1:
            begin
                mix_next = x0 * MIX_MUL;
            end
            S_MIX2:
            begin
                mix_next = x1 * MIX_MUL;
                idx_next = '0;
            end
            S_FIND:
            begin
                pv_next    = issuing;
                paddr_next = idx_reg[AW-1:0];
                idx_next   = idx_reg + FW'(issuing);
                if (hash_gt || scan_end)
                begin
                    pos_next      = find_pos;
                    idx_next      = fill_reg - 1'b1;
                    issue_on_next = ({1'b0, find_pos} < {1'b0, fill_reg[AW-1:0]})
                                    && (fill_reg != '0);
                    pv_next       = 1'b0;
                end
            end
            S_SHIFT:
            begin
                // Entries move up one place, highest first, so a read never
                // sees a slot that has already been overwritten.
                if (issue_on_reg)
                begin
                    pv_next    = 1'b1;
                    paddr_next = idx_reg[AW-1:0];
                    if (idx_reg[AW-1:0] == pos_reg)
                        issue_on_next = 1'b0;
                    else
                        idx_next = idx_reg - 1'b1;
                end
                if (pv_reg)
                begin
                    we    = 1'b1;
                    waddr = paddr_reg + 1'b1;
                    wdata = rd_reg;
                end
            end
            S_PLACE:
            begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata.id   = cmd_reg.id;
                wdata.hash = label_h;
                fill_next  = fill_reg + 1'b1;
                rep_next   = rep_reg + 1'b1;
                label_next = label_reg + LABEL_STEP;
                if (rep_reg == 2'(REPLICAS - 1))
                    count_next = count_reg + 1'b1;
            end
            S_REMOVE:
            begin
                // Compaction pass: entries of other servers are written back
                // at the running write pointer.
                pv_next    = issuing;
                paddr_next = idx_reg[AW-1:0];
                idx_next   = idx_reg + FW'(issuing);
                if (pv_reg)
                begin
                    if (id_match)
                        found_next = 1'b1;
                    else
                    begin
                        we      = 1'b1;
                        waddr   = wr_reg;
                        wdata   = rd_reg;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                if (scan_end)
                begin
                    if (found_reg)
                    begin
                        fill_next  = fill_reg - FW'(REPLICAS);
                        count_next = count_reg - 1'b1;
                    end
                    else
                        res_status_next = ST_UNKNOWN;
                end
            end
            S_LOOKUP:
            begin
                pv_next    = issuing;
                paddr_next = idx_reg[AW-1:0];
                idx_next   = idx_reg + FW'(issuing);
                if (key_lt)
                    res_id_next = rd_reg.id;
            end
            S_WRAP:
            begin
                raddr = '0;
            end
            S_WRAP_RD:
            begin
                res_id_next = rd_reg.id;
            end
            S_REPLY:
            begin
                cmd_ready = 1'b0;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            ring_mem[waddr] <= wdata;
        rd_reg <= ring_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        paddr_reg      <= paddr_next;
        rep_reg        <= rep_next;
        label_reg      <= label_next;
        mix_reg        <= mix_next;
        pos_reg        <= pos_next;
        wr_reg         <= wr_next;
        found_reg      <= found_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_REPLY && slot_free)
        begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_on_reg  <= 1'b0;
            pv_reg        <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_on_reg <= issue_on_next;
            pv_reg       <= pv_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            if (state_reg == S_REPLY && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_id     = out_id_reg;
    assign out_status = out_status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("ring fill beyond depth");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg == FW'(32'(count_reg) * REPLICAS)))
        else $error("ring fill does not match server count");

    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE && rep_reg == 2'(REPLICAS - 1))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("server count not advanced after add");

    a_reply_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPLY && slot_free) |=> out_valid_reg)
        else $error("reply not presented");

endmodule

/* rtl/core/consistent_hash_ring.sv */
// Top level of the consistent hash ring: front end, command queue and
// ring engine. Depends on chr_pkg, chr_front, chr_cmd_fifo and chr_back.
`timescale 1ns / 1ps

// Usage:
// Slave channel s_*: one transaction per item. s_tuser is the kind (add,
// remove, key byte), s_tlast marks the final key byte. Key bytes only
// update the running djb2 hash; the final byte queues a lookup.
// Master channel m_*: one result per add, remove or final key byte, with
// the server in m_tdata and the status code in m_tuser.
// Ring walk: the ring engine walks its ring memory one entry a cycle, with
// one read and one write per cycle. A remove makes one pass over the ring
// and a lookup at most one; an add makes a presence scan plus three search
// and shift passes, with each replica's label hashed in the S_MIX1 and
// S_MIX2 states. Items are taken one at a time by the engine; a two-entry
// queue lets the front end keep accepting meanwhile.
// Reset empties the ring and sets the key hash to its seed; no clearing
// pass is needed. If m_tready is low, the result holds in the output
// register, the engine finishes its next command and waits, and the
// queue fills before s_tready drops.

module consistent_hash_ring
#(
    parameter int MAX_SERVERS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // server [16:0], key byte [24:17], zero pad
    input  logic [1:0]  s_tuser,   // kind [1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // chosen_server [16:0], zero pad
    output logic [2:0]  m_tuser    // status [2:0]
);
    import chr_pkg::*;

    logic                 push_valid;
    logic                 push_ready;
    cmd_t                 push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    cmd_t                 pop_data;
    logic [ID_W-1:0]      res_id;
    logic [STATUS_W-1:0]  res_status;

    chr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_id      (s_tdata[16:0]),
        .in_byte    (s_tdata[24:17]),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    chr_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    chr_back #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd_data   (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_id     (res_id),
        .out_status (res_status)
    );

    assign m_tdata = {7'b0, res_id};
    assign m_tuser = res_status;

endmodule
